// ===== design/bbb_pkg.sv =====
// bbb_pkg: shared widths, reset values, codes and helpers for the band breakout trader.
// Depends on nothing; bbb_mul, the top level and the bench import it.
`timescale 1ns / 1ps

package bbb_pkg;

  localparam int PRICE_W        = 24;
  localparam int WLEN_W         = 9;
  localparam int LIMIT_W        = 10;
  localparam int MULT_W         = 4;
  localparam int ACT_W          = 2;
  localparam int POS_W          = 11;
  localparam int CASH_W         = 48;
  localparam int DIGIT_W        = 16;
  localparam int APB_AW         = 4;
  localparam int APB_DW         = 32;
  localparam int WINDOW_MAX_DEF = 256;

  localparam logic [WLEN_W-1:0]  WLEN_RST  = 9'd20;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 10'd5;
  localparam logic [MULT_W-1:0]  MULT_RST  = 4'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WLEN  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_MULT  = 2'd2;

  localparam logic signed [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W-1){1'b1}}};
  localparam logic signed [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W-1){1'b0}}};

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVSQ,
    ST_NEWSQ,
    ST_NP,
    ST_DD,
    ST_LHS,
    ST_NQ,
    ST_SS,
    ST_K,
    ST_RHS,
    ST_TRADE,
    ST_MTM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // clamp a two-bit-wider signed sum into the signed cash range
  function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [CASH_W+1:0] v);
    logic [2:0] top;
    top = v[CASH_W+1:CASH_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[CASH_W-1:0];
    end else if (v[CASH_W+1]) begin
      return CASH_MIN;
    end else begin
      return CASH_MAX;
    end
  endfunction

endpackage

// ===== design/bbb_ram.sv =====
// bbb_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module bbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bbb_mul.sv =====
// bbb_mul: iterative unsigned multiplier, one 16-bit digit of b per cycle.
// Depends on bbb_pkg for the digit width and the status struct.
`timescale 1ns / 1ps

module bbb_mul
  import bbb_pkg::*;
#(
  parameter int AW = 66,
  parameter int BW = 33,
  parameter int PW = 83
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output mul_stat_t     stat,
  output logic [PW-1:0] prod
);

  localparam int ND = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int IW = (ND > 1) ? $clog2(ND) : 1;

  logic [AW-1:0]         a_r;
  logic [BW-1:0]         b_r;
  logic [BW-1:0]         b_next;
  logic [IW-1:0]         idx;
  logic [PW-1:0]         acc;
  logic                  busy;
  logic                  done;
  logic [AW+DIGIT_W-1:0] term;
  logic [PW-1:0]         term_sh;

  assign term    = a_r * b_r[DIGIT_W-1:0];
  assign term_sh = PW'(term) << (idx * DIGIT_W);
  assign b_next  = b_r >> DIGIT_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        idx  <= '0;
        acc  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + term_sh;
        b_r <= b_next;
        idx <= idx + 1'b1;
        // stop once no digits remain
        if (b_next == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign prod      = acc;

endmodule

// ===== design/bollinger_band_breakout_trader.sv =====
// bollinger_band_breakout_trader: top level, APB registers, sequencer and datapath.
// Depends on bbb_pkg, bbb_ram (price ring) and bbb_mul (shared multiplier).
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid / in_ready with one price (hundredths) per transaction.
//   Output channel: out_valid / out_ready with action, position, cash and pnl,
//   exactly one result transaction per input transaction, in order.
//   Registers: window_len at 0x0, position_limit at 0x4, band_mult at 0x8.
//   Writing window_len restarts the window; position and cash are kept.
//   Processing: each price takes up to ten passes through the one shared
//   multiplier, which takes a 16-bit digit of its second operand per cycle,
//   plus the ring read, trade decision and output load. One price is in
//   flight at a time; in_ready is high only while the sequencer is idle.
//   Reset (synchronous, active high) restores register defaults and empties the
//   window, position and cash. The price ring is not cleared: entries are only
//   read after being written since the last restart.
//   Stall: a finished result sits in the output register; the next price may be
//   accepted meanwhile, and its result is held back until the old one is taken.

module bollinger_band_breakout_trader
  import bbb_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [PRICE_W-1:0]        price,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ACT_W-1:0]          action,
  output logic signed [POS_W-1:0]   position,
  output logic signed [CASH_W-1:0]  cash,
  output logic signed [CASH_W-1:0]  pnl
);

  // widths that follow from the window depth
  localparam int NW    = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int SW    = PRICE_W + NW;
  localparam int QW    = 2 * PRICE_W + NW;
  localparam int DDW   = 2 * SW;
  localparam int LW    = DDW + NW;
  localparam int VW    = QW + NW;
  localparam int KW    = 2 * MULT_W + NW;
  localparam int RW    = VW + KW;
  localparam int AW    = (DDW > VW) ? DDW : VW;
  localparam int BW    = SW;
  localparam int PW    = (LW > RW) ? LW : RW;
  localparam int CW    = (NW > WLEN_W) ? NW : WLEN_W;

  // configuration
  logic [WLEN_W-1:0]  wlen;
  logic [LIMIT_W-1:0] limit;
  logic [MULT_W-1:0]  bmult;
  logic               cfg_we;
  logic               wlen_we;

  // sequencer
  state_t state;
  state_t state_next;
  logic   issued;
  logic   step_done;

  // window state
  logic [PTR_W-1:0] ring_ptr;
  logic [NW-1:0]    fill_count;
  logic [SW-1:0]    wsum;
  logic [QW-1:0]    wsq;
  logic signed [POS_W-1:0]  held;
  logic signed [CASH_W-1:0] cash_total;

  // per-item working registers
  logic [PRICE_W-1:0] price_r;
  logic [PRICE_W-1:0] old_price;
  logic               up_r;
  logic               down_r;
  logic [SW-1:0]      dmag;
  logic [DDW-1:0]     dd;
  logic [LW-1:0]      lhs;
  logic [VW-1:0]      nq;
  logic [VW-1:0]      var_r;
  logic [KW-1:0]      kmul;
  logic               band;
  logic signed [CASH_W-1:0] pnl_r;
  action_t            act_r;

  // output register
  action_t                  out_act;
  logic signed [POS_W-1:0]  out_pos;
  logic signed [CASH_W-1:0] out_cash;
  logic signed [CASH_W-1:0] out_pnl;
  logic                     out_load;

  // shared multiplier
  logic          mul_start;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  mul_stat_t     mstat;
  logic [PW-1:0] mul_prod;

  // ring memory
  logic [PTR_W-1:0]   old_idx;
  logic [NW:0]        idx_diff;
  logic [PRICE_W-1:0] ram_rdata;
  logic               ram_we;

  // combinational helpers
  logic [NW-1:0]         len_eff;
  logic                  evict;
  logic [SW-1:0]         np_val;
  logic [2*MULT_W-1:0]   bm_sq;
  logic [POS_W-1:0]      held_mag;
  logic signed [POS_W:0] held_x;
  logic signed [POS_W:0] lim_x;
  logic                  buy;
  logic                  sell;
  logic signed [CASH_W+1:0] cash_x;
  logic signed [CASH_W+1:0] price_x;
  logic signed [CASH_W+1:0] mtm_x;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign wlen_we = cfg_we && (paddr[3:2] == REG_WLEN);

  always_comb begin
    case (paddr[3:2])
      REG_WLEN:  prdata = APB_DW'(wlen);
      REG_LIMIT: prdata = APB_DW'(limit);
      REG_MULT:  prdata = APB_DW'(bmult);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen  <= WLEN_RST;
      limit <= LIMIT_RST;
      bmult <= MULT_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_WLEN:  wlen  <= pwdata[WLEN_W-1:0];
        REG_LIMIT: limit <= pwdata[LIMIT_W-1:0];
        REG_MULT:  bmult <= pwdata[MULT_W-1:0];
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------- helpers
  // clamp window length to 1..WINDOW_MAX
  always_comb begin
    if (wlen == '0) begin
      len_eff = NW'(1);
    end else if (CW'(wlen) > CW'(WINDOW_MAX)) begin
      len_eff = NW'(WINDOW_MAX);
    end else begin
      len_eff = NW'(wlen);
    end
  end

  assign evict = (fill_count >= len_eff) && (fill_count != '0);

  // oldest entry sits fill_count places behind the write pointer
  assign idx_diff = (NW+1)'(ring_ptr) - (NW+1)'(fill_count);
  assign old_idx  = idx_diff[NW] ? PTR_W'(idx_diff + (NW+1)'(WINDOW_MAX))
                                 : PTR_W'(idx_diff);

  assign np_val   = mul_prod[SW-1:0];
  assign bm_sq    = bmult * bmult;
  assign held_mag = held[POS_W-1] ? (~held + 1'b1) : held;
  assign held_x   = {held[POS_W-1], held};
  assign lim_x    = {2'b00, limit};
  assign buy      = band && up_r   && (held_x < lim_x);
  assign sell     = band && down_r && (held_x > -lim_x);
  assign cash_x   = {{2{cash_total[CASH_W-1]}}, cash_total};
  assign price_x  = (CASH_W+2)'(price_r);
  assign mtm_x    = (CASH_W+2)'(mul_prod[PRICE_W+LIMIT_W-1:0]);

  assign step_done = issued && mstat.done;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_FETCH;
      ST_FETCH: state_next = evict ? ST_EVSQ : ST_NEWSQ;
      ST_EVSQ:  if (step_done) state_next = ST_NEWSQ;
      ST_NEWSQ: if (step_done) state_next = ST_NP;
      ST_NP: begin
        if (step_done) begin
          state_next = (np_val != wsum) ? ST_DD : ST_TRADE;
        end
      end
      ST_DD:    if (step_done) state_next = ST_LHS;
      ST_LHS:   if (step_done) state_next = ST_NQ;
      ST_NQ:    if (step_done) state_next = ST_SS;
      ST_SS:    if (step_done) state_next = ST_K;
      ST_K:     if (step_done) state_next = ST_RHS;
      ST_RHS:   if (step_done) state_next = ST_TRADE;
      ST_TRADE: state_next = ST_MTM;
      ST_MTM:   if (step_done) state_next = ST_EMIT;
      ST_EMIT:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_EVSQ:  begin mul_start = !issued; mul_a = AW'(old_price); mul_b = BW'(old_price); end
      ST_NEWSQ: begin mul_start = !issued; mul_a = AW'(price_r);   mul_b = BW'(price_r);   end
      ST_NP:    begin mul_start = !issued; mul_a = AW'(price_r);   mul_b = BW'(fill_count); end
      ST_DD:    begin mul_start = !issued; mul_a = AW'(dmag);      mul_b = dmag;           end
      ST_LHS:   begin
        mul_start = !issued;
        mul_a     = AW'(dd);
        mul_b     = BW'(fill_count - 1'b1);
      end
      ST_NQ:    begin mul_start = !issued; mul_a = AW'(wsq);       mul_b = BW'(fill_count); end
      ST_SS:    begin mul_start = !issued; mul_a = AW'(wsum);      mul_b = wsum;           end
      ST_K:     begin mul_start = !issued; mul_a = AW'(fill_count); mul_b = BW'(bm_sq);    end
      ST_RHS:   begin mul_start = !issued; mul_a = AW'(var_r);     mul_b = BW'(kmul);      end
      ST_MTM:   begin mul_start = !issued; mul_a = AW'(price_r);   mul_b = BW'(held_mag);  end
      default:  ;
    endcase
  end

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_EMIT) && (!out_valid || out_ready);
  assign ram_we   = (state == ST_NEWSQ) && step_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start) begin
        issued <= 1'b1;
      end else if (step_done) begin
        issued <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- window and account
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_ptr   <= '0;
      fill_count <= '0;
      wsum       <= '0;
      wsq        <= '0;
      held       <= '0;
      cash_total <= '0;
    end else if (wlen_we) begin
      // restart the window, keep the account
      ring_ptr   <= '0;
      fill_count <= '0;
      wsum       <= '0;
      wsq        <= '0;
    end else begin
      case (state)
        ST_EVSQ: begin
          if (step_done) begin
            wsq        <= wsq - mul_prod[QW-1:0];
            wsum       <= wsum - SW'(old_price);
            fill_count <= fill_count - 1'b1;
          end
        end
        ST_NEWSQ: begin
          if (step_done) begin
            wsq        <= wsq + mul_prod[QW-1:0];
            wsum       <= wsum + SW'(price_r);
            fill_count <= fill_count + 1'b1;
            ring_ptr   <= (ring_ptr == PTR_W'(WINDOW_MAX - 1)) ? '0 : ring_ptr + 1'b1;
          end
        end
        ST_TRADE: begin
          if (buy) begin
            held       <= held + 1'b1;
            cash_total <= sat_cash(cash_x - price_x);
          end else if (sell) begin
            held       <= held - 1'b1;
            cash_total <= sat_cash(cash_x + price_x);
          end
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE:  if (in_valid) price_r <= price;
      ST_FETCH: old_price <= ram_rdata;
      ST_NP: begin
        if (step_done) begin
          up_r   <= np_val > wsum;
          down_r <= np_val < wsum;
          dmag   <= (np_val > wsum) ? (np_val - wsum) : (wsum - np_val);
          band   <= 1'b0;
        end
      end
      ST_DD:    if (step_done) dd    <= mul_prod[DDW-1:0];
      ST_LHS:   if (step_done) lhs   <= mul_prod[LW-1:0];
      ST_NQ:    if (step_done) nq    <= mul_prod[VW-1:0];
      ST_SS:    if (step_done) var_r <= nq - mul_prod[VW-1:0];
      ST_K:     if (step_done) kmul  <= mul_prod[KW-1:0];
      ST_RHS:   if (step_done) band  <= PW'(lhs) > mul_prod;
      ST_TRADE: act_r <= buy ? ACT_BUY : (sell ? ACT_SELL : ACT_NONE);
      ST_MTM: begin
        // held was updated in the trade step; product is |held| * price
        if (step_done) begin
          pnl_r <= sat_cash(held[POS_W-1] ? (cash_x - mtm_x) : (cash_x + mtm_x));
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_act  <= act_r;
      out_pos  <= held;
      out_cash <= cash_total;
      out_pnl  <= pnl_r;
    end
  end

  assign action   = out_act;
  assign position = out_pos;
  assign cash     = out_cash;
  assign pnl      = out_pnl;

  // ---------------------------------------------------------------- submodules
  bbb_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_ptr),
    .wdata (price_r),
    .raddr (old_idx),
    .rdata (ram_rdata)
  );

  bbb_mul #(
    .AW (AW),
    .BW (BW),
    .PW (PW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mstat),
    .prod  (mul_prod)
  );

  // ---------------------------------------------------------------- assertions
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= NW'(WINDOW_MAX))
    else $error("window fill beyond depth");

  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mstat.busy)
    else $error("multiplier started while busy");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held != {1'b1, {(POS_W-1){1'b0}}})
    else $error("position out of range");

  a_buy_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRADE && buy) |=> (held == $past(held) + 1'b1))
    else $error("buy did not raise position");

endmodule

// ===== dv/bollinger_band_breakout_trader_tb.sv =====
// Self-checking bench for the band breakout trader: price transactions in, trade reports out.
// Depends on bbb_pkg and the bollinger_band_breakout_trader RTL; reads no files.
`timescale 1ns / 1ps

// Scoreboard: owns a shadow copy of the trader state and a queue of predicted reports.
class trade_scoreboard;
  logic [8:0]   wlen;
  logic [9:0]   lim;
  logic [3:0]   mult;
  logic [23:0]  ring [256];
  int unsigned  wptr;
  int unsigned  fill;
  logic [31:0]  wsum;
  logic [55:0]  wsq;
  int           held;
  longint       cash_acc;
  logic [1:0]   exp_act [$];
  logic [10:0]  exp_pos [$];
  logic [47:0]  exp_cash [$];
  logic [47:0]  exp_pnl [$];
  int           errors;
  int           n_checked;
  int           n_trades;

  function new();
    wlen = 20; lim = 5; mult = 2;
    wptr = 0; fill = 0; wsum = 0; wsq = 0;
    held = 0; cash_acc = 0; errors = 0; n_checked = 0; n_trades = 0;
  endfunction

  function void write_reg(int idx, logic [31:0] v);
    if (idx == 0) begin
      wlen = v[8:0];
      wptr = 0; fill = 0; wsum = 0; wsq = 0;
    end else if (idx == 1) begin
      lim = v[9:0];
    end else if (idx == 2) begin
      mult = v[3:0];
    end
  endfunction

  static function longint clamp48(longint v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v;
  endfunction

  // Predict one report from an accepted price.
  function void note_price(logic [23:0] p);
    int unsigned len;
    logic [23:0] old;
    logic [63:0] np, dmag;
    logic [127:0] lhs, rhs, var_w;
    bit up, down, band;
    logic [1:0] act;
    longint pv;
    len = wlen;
    if (len < 1) len = 1;
    if (len > 256) len = 256;
    if (fill >= len && fill > 0) begin
      old = ring[(wptr + 256 - fill) % 256];
      wsum -= old;
      wsq -= 56'(old) * 56'(old);
      fill--;
    end
    ring[wptr] = p;
    wptr = (wptr + 1) % 256;
    wsum += p;
    wsq += 56'(p) * 56'(p);
    fill++;
    np = 64'(fill) * 64'(p);
    up = np > 64'(wsum);
    down = np < 64'(wsum);
    dmag = up ? np - 64'(wsum) : 64'(wsum) - np;
    band = 0;
    if (up || down) begin
      lhs = 128'(dmag) * 128'(dmag) * 128'(fill - 1);
      var_w = 128'(wsq) * 128'(fill) - 128'(wsum) * 128'(wsum);
      rhs = var_w * 128'(mult) * 128'(mult) * 128'(fill);
      band = lhs > rhs;
    end
    act = bbb_pkg::ACT_NONE;
    pv = longint'(p);
    if (band && up && held < int'(lim)) begin
      held++;
      cash_acc = clamp48(cash_acc - pv);
      act = bbb_pkg::ACT_BUY;
    end else if (band && down && held > -int'(lim)) begin
      held--;
      cash_acc = clamp48(cash_acc + pv);
      act = bbb_pkg::ACT_SELL;
    end
    exp_act.insert(exp_act.size(), act);
    exp_pos.insert(exp_pos.size(), 11'(held));
    exp_cash.insert(exp_cash.size(), 48'(cash_acc));
    exp_pnl.insert(exp_pnl.size(), 48'(clamp48(cash_acc + longint'(held) * pv)));
  endfunction

  function void check_report(logic [1:0] a, logic [10:0] ps, logic [47:0] c, logic [47:0] pl);
    if (exp_act.size() == 0) begin
      $error("report with no price outstanding: action %0d", a);
      errors++;
      return;
    end
    if (a != exp_act[0]) begin
      $error("action expected %0d got %0d", exp_act[0], a); errors++;
    end
    if (ps != exp_pos[0]) begin
      $error("position expected %0d got %0d", $signed(exp_pos[0]), $signed(ps)); errors++;
    end
    if (c != exp_cash[0]) begin
      $error("cash expected %0d got %0d", $signed(exp_cash[0]), $signed(c)); errors++;
    end
    if (pl != exp_pnl[0]) begin
      $error("pnl expected %0d got %0d", $signed(exp_pnl[0]), $signed(pl)); errors++;
    end
    if (a != bbb_pkg::ACT_NONE) n_trades++;
    n_checked++;
    void'(exp_act.pop_front()); void'(exp_pos.pop_front());
    void'(exp_cash.pop_front()); void'(exp_pnl.pop_front());
  endfunction

  function int outstanding();
    return exp_act.size();
  endfunction
endclass

module bollinger_band_breakout_trader_tb;
  import bbb_pkg::*;

  localparam int WDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic [PRICE_W-1:0] price = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [ACT_W-1:0] action;
  logic signed [POS_W-1:0] position;
  logic signed [CASH_W-1:0] cash, pnl;

  // idle and stall percentages for the current phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  trade_scoreboard ledger;

  always #6 clk = ~clk;

  bollinger_band_breakout_trader uut (.*);

  // Receiver: randomise ready each cycle and check every report taken.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        ledger.check_report(action, position, cash, pnl);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles with no transaction on either channel or on the register bus.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired with %0d reports outstanding", ledger.outstanding());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one price; hold it until accepted, then note it with the scoreboard.
  // Valid stays high after the accept so back-to-back prices need no gap.
  task automatic send_price(input logic [23:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    price <= p;
    do @(posedge clk); while (!in_ready);
    ledger.note_price(p);
  endtask

  // Hold off until every predicted report has been taken, then let the pipe drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Register write: setup, then access, then the bus is left idle.
  task automatic reg_write(input int idx, input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_AW'(idx * 4); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    ledger.write_reg(idx, v);
    @(posedge clk);
  endtask

  // Random price: mostly a drifting walk with breakouts, some full-range noise.
  logic [23:0] walk;
  function automatic logic [23:0] next_price();
    int step;
    case ($urandom_range(9))
      0: return 24'($urandom);
      1: return ($urandom_range(1)) ? 24'hFFFFFF : 24'h0;
      2: begin
        step = $urandom_range(200000) - 100000;
      end
      default: begin
        step = $urandom_range(2000) - 1000;
      end
    endcase
    if (int'(walk) + step < 0) walk = 0;
    else if (int'(walk) + step > 24'hFFFFFF) walk = 24'hFFFFFF;
    else walk = 24'(int'(walk) + step);
    return walk;
  endfunction

  task automatic random_phase(input int count, input int sidle, input int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (count) send_price(next_price());
  endtask

  initial begin
    ledger = new();
    walk = 24'd500000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset defaults, extremes, first-price case, breakouts both ways.
    send_price(24'd1000);
    send_price(24'd1000);
    send_price(24'hFFFFFF);
    send_price(24'h0);
    send_price(24'h0);
    send_price(24'hFFFFFF);
    send_price(24'h555555);
    send_price(24'hAAAAAA);
    drain();
    // Window of one never trades; band of zero trades on any move.
    reg_write(0, 32'd1);
    reg_write(2, 32'd0);
    send_price(24'd10); send_price(24'd20); send_price(24'd5);
    drain();
    reg_write(0, 32'd0);
    send_price(24'd7); send_price(24'd9);
    drain();
    // Tight limit, then lower it below the holding.
    reg_write(0, 32'd3);
    reg_write(1, 32'd2);
    repeat (4) send_price(24'hFFFFFF);
    send_price(24'd1);
    drain();
    reg_write(1, 32'd0);
    send_price(24'hFFFFFF); send_price(24'd1); send_price(24'hFFFFFF);
    drain();
    reg_write(3, 32'hFFFF_FFFF);  // unmapped: must be ignored

    // Random phases across settings, including the extremes.
    reg_write(0, 32'd20); reg_write(1, 32'd1023); reg_write(2, 32'd15);
    random_phase(300, 0, 0);
    drain();
    reg_write(0, 32'd2); reg_write(1, 32'd5); reg_write(2, 32'd1);
    random_phase(300, 68, 0);
    drain();
    reg_write(0, 32'd256); reg_write(2, 32'd2);
    random_phase(400, 0, 68);
    drain();
    reg_write(0, 32'd511); reg_write(1, 32'd1023); reg_write(2, 32'd0);
    random_phase(300, 35, 35);
    drain();
    reg_write(0, 32'd8); reg_write(1, 32'd3); reg_write(2, 32'd1);
    random_phase(300, 0, 0);
    drain();
    reg_write(0, 32'd5); reg_write(1, 32'd1023); reg_write(2, 32'd0);
    random_phase(300, 35, 35);

    send_idle_pct = 0;
    drain();
    $display("checked %0d reports, %0d of them trades, over six register settings",
             ledger.n_checked, ledger.n_trades);
    if (ledger.errors == 0 && ledger.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
